/* design/akf_pkg.sv */
// Shared types, widths and saturation helpers of the angle/rate Kalman filter.
package akf_pkg;

	localparam int AngW  = 32;  // Q16.16 angle, rate, bias
	localparam int CovW  = 48;  // Q16.32 covariance, noise, gain
	localparam int DtW   = 16;  // Q0.16 time step
	localparam int OpW   = 50;  // signed operand width of the shared units
	localparam int MagW  = 49;  // magnitude width of an operand
	localparam int DigW  = 17;  // multiplier digit
	localparam int NDig  = 3;   // digits per operand
	localparam int AccW  = MagW + DigW * NDig;
	localparam int ResW  = 64;  // multiplier result, capped at 2^62
	localparam int SumW  = 66;  // headroom for sums before saturation
	localparam int DvdW  = 80;  // dividend (numerator << 32)
	localparam int RemW  = 50;
	localparam int CntW  = 7;   // holds DvdW
	localparam int CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] CFG_ANGLE_NOISE   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_BIAS_NOISE    = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_MEASURE_NOISE = 2'd2;

	localparam logic [CovW-1:0] ANGLE_NOISE_RST   = 48'd4294967;
	localparam logic [CovW-1:0] BIAS_NOISE_RST    = 48'd12884902;
	localparam logic [CovW-1:0] MEASURE_NOISE_RST = 48'd128849019;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	typedef enum logic [3:0] {
		STP_RATE, STP_DP11, STP_T, STP_QB, STP_K0, STP_K1,
		STP_A, STP_B, STP_P10, STP_P11, STP_P00, STP_P01
	} step_t;

	typedef struct packed {
		logic                  start;
		logic signed [OpW-1:0] a;
		logic signed [OpW-1:0] b;
		logic                  sh32;
	} mul_req_t;

	typedef struct packed {
		logic                   start;
		logic signed [CovW-1:0] num;
		logic signed [OpW-1:0]  den;
	} div_req_t;

	function automatic logic signed [AngW-1:0] sat32(input logic signed [SumW-1:0] x);
		logic hi;
		logic lo;
		hi = &x[SumW-1:AngW-1];
		lo = |x[SumW-1:AngW-1];
		if (hi || !lo) return x[AngW-1:0];
		return x[SumW-1] ? {1'b1, {(AngW-1){1'b0}}} : {1'b0, {(AngW-1){1'b1}}};
	endfunction

	function automatic logic signed [CovW-1:0] sat48(input logic signed [SumW-1:0] x);
		logic hi;
		logic lo;
		hi = &x[SumW-1:CovW-1];
		lo = |x[SumW-1:CovW-1];
		if (hi || !lo) return x[CovW-1:0];
		return x[SumW-1] ? {1'b1, {(CovW-1){1'b0}}} : {1'b0, {(CovW-1){1'b1}}};
	endfunction

endpackage

/* design/akf_if.sv */
// Handshake channels of the filter: input sample item and result item.
interface akf_in_if;
	import akf_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [AngW-1:0] measured_angle;
	logic signed [AngW-1:0] measured_rate;
	logic [DtW-1:0]         time_step;
	logic                   set_angle;
	modport source (output valid, measured_angle, measured_rate, time_step, set_angle,
		input ready);
	modport sink (input valid, measured_angle, measured_rate, time_step, set_angle,
		output ready);
endinterface

interface akf_out_if;
	import akf_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [AngW-1:0] filtered_angle;
	modport source (output valid, filtered_angle, input ready);
	modport sink (input valid, filtered_angle, output ready);
endinterface

/* design/akf_mul.sv */
// Shared signed multiplier: digit-serial product, shift, cap at 2^62.
module akf_mul import akf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mul_req_t              req,
	output logic                  done,
	output logic signed [ResW-1:0] res
);
	logic                busy_q, fin_q, done_q, neg_q, sh32_q;
	logic [1:0]          cnt_q;
	logic [MagW-1:0]     amag_q;
	logic [DigW*NDig-1:0] bmag_q;
	logic [AccW-1:0]     acc_q;
	logic signed [ResW-1:0] res_q;
	logic [OpW-1:0]      amag, bmag;
	logic [AccW-1:0]     shifted;
	logic [ResW-1:0]     capped;

	assign amag = req.a[OpW-1] ? OpW'(-req.a) : OpW'(req.a);
	assign bmag = req.b[OpW-1] ? OpW'(-req.b) : OpW'(req.b);
	assign shifted = sh32_q ? (acc_q >> 32) : (acc_q >> 16);
	assign capped = (shifted > AccW'(64'h4000_0000_0000_0000)) ? 64'h4000_0000_0000_0000
		: shifted[ResW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'(NDig - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			amag_q <= amag[MagW-1:0];
			bmag_q <= (DigW*NDig)'(bmag[MagW-1:0]);
			acc_q  <= '0;
			neg_q  <= req.a[OpW-1] ^ req.b[OpW-1];
			sh32_q <= req.sh32;
		end else if (busy_q) begin
			acc_q  <= (acc_q << DigW) + AccW'(amag_q * bmag_q[DigW*NDig-1 -: DigW]);
			bmag_q <= bmag_q << DigW;
		end else if (fin_q) begin
			res_q <= neg_q ? -$signed(capped) : $signed(capped);
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule

/* design/akf_div.sv */
// Restoring divider for the gain: (num << 32) / den, one bit a cycle, saturated to 48 bits.
module akf_div import akf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  div_req_t               req,
	output logic                   done,
	output logic signed [CovW-1:0] quo
);
	logic                busy_q, fin_q, done_q, neg_q;
	logic [CntW-1:0]     cnt_q;
	logic [DvdW-1:0]     dvd_q, q_q;
	logic [RemW-1:0]     rem_q, ud_q, rem_sh;
	logic signed [CovW-1:0] quo_q;
	logic [OpW-1:0]      unum, uden;
	logic                ge;

	assign unum = req.num[CovW-1] ? OpW'(-$signed(req.num)) : OpW'($signed(req.num));
	assign uden = req.den[OpW-1] ? OpW'(-req.den) : OpW'(req.den);
	assign rem_sh = {rem_q[RemW-2:0], dvd_q[DvdW-1]};
	assign ge = rem_sh >= ud_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= (req.den != '0);
				fin_q  <= (req.den == '0);
				cnt_q  <= CntW'(DvdW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= {unum[DvdW-33:0], 32'd0};
			ud_q  <= uden;
			rem_q <= '0;
			q_q   <= '0;
			neg_q <= req.num[CovW-1] ^ req.den[OpW-1];
		end else if (busy_q) begin
			rem_q <= ge ? rem_sh - ud_q : rem_sh;
			q_q   <= {q_q[DvdW-2:0], ge};
			dvd_q <= dvd_q << 1;
		end else if (fin_q) begin
			if (!neg_q)
				quo_q <= (q_q > DvdW'({1'b0, {(CovW-1){1'b1}}}))
					? {1'b0, {(CovW-1){1'b1}}} : q_q[CovW-1:0];
			else
				quo_q <= (q_q > DvdW'({1'b1, {(CovW-1){1'b0}}}))
					? {1'b1, {(CovW-1){1'b0}}} : -$signed(q_q[CovW-1:0]);
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

/* design/angle_rate_kalman_filter.sv */
// Top level of the two-state angle/gyro-bias Kalman filter.
// One sample item per update; the filter is busy while it works and takes no new item.
// A normal item runs twelve steps on two shared units: ten multiplications on the
// digit-serial multiplier (3 digits, then cap and sign) and two gain divisions on
// the restoring divider (one quotient bit a cycle over an 80-bit dividend, skipped
// when the divisor is zero). Each step has an issue state and a wait state, and the
// finished angle is then loaded into the output register; the divider sets most of
// an item's time. A set_angle item loads the angle and goes straight to that load.
// The result sits in an output register, so a slow consumer only holds the next
// item off once the following result is ready. Noise registers are written through
// the plain write port; the user must write them only while idle, as the block
// itself does not enforce it.
module angle_rate_kalman_filter import akf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	akf_in_if.sink             sample,
	akf_out_if.source          estimate,
	input  logic               cfg_wr_en,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CovW-1:0]    cfg_data
);
	state_t state_q;
	step_t  step_q;

	// noise registers
	logic [CovW-1:0] qa_q, qb_q, rm_q;

	// filter state
	logic signed [AngW-1:0] angle_q, bias_q;
	logic signed [CovW-1:0] p00_q, p01_q, p10_q, p11_q;

	// latched item and intermediates
	logic signed [AngW-1:0] meas_q, rate_q;
	logic [DtW-1:0]         dt_q;
	logic signed [CovW-1:0] t_q, k0_q, k1_q;
	logic signed [AngW:0]   y_q;

	logic                   out_valid_q;
	logic signed [AngW-1:0] out_q;

	mul_req_t mreq;
	div_req_t dreq;
	logic     mdone, ddone;
	logic signed [ResW-1:0] mres;
	logic signed [CovW-1:0] dquo;

	logic signed [OpW-1:0]  dt_op, rate_op, s_sum;
	logic signed [SumW-1:0] mx;
	logic                   is_div, last_step;

	akf_mul u_mul (.clk, .arst_n, .req(mreq), .done(mdone), .res(mres));
	akf_div u_div (.clk, .arst_n, .req(dreq), .done(ddone), .quo(dquo));

	assign dt_op   = $signed({{(OpW-DtW){1'b0}}, dt_q});
	assign rate_op = OpW'(rate_q) - OpW'(bias_q);
	assign s_sum   = OpW'(p00_q) + $signed({{(OpW-CovW){1'b0}}, rm_q});
	assign mx      = SumW'(mres);
	assign is_div  = (step_q == STP_K0) || (step_q == STP_K1);
	assign last_step = (step_q == STP_P01);

	// operand select for the shared units
	always_comb begin
		mreq = '0;
		dreq = '0;
		mreq.start = (state_q == ST_ISSUE) && !is_div;
		dreq.start = (state_q == ST_ISSUE) && is_div;
		dreq.den   = s_sum;
		dreq.num   = (step_q == STP_K1) ? p10_q : p00_q;
		case (step_q)
			STP_RATE: begin mreq.a = dt_op; mreq.b = rate_op; end
			STP_DP11: begin mreq.a = dt_op; mreq.b = OpW'(p11_q); end
			STP_T:    begin mreq.a = dt_op; mreq.b = OpW'(t_q); end
			STP_QB:   begin mreq.a = $signed({{(OpW-CovW){1'b0}}, qb_q}); mreq.b = dt_op; end
			STP_A:    begin mreq.a = OpW'(k0_q); mreq.b = OpW'(y_q); mreq.sh32 = 1'b1; end
			STP_B:    begin mreq.a = OpW'(k1_q); mreq.b = OpW'(y_q); mreq.sh32 = 1'b1; end
			STP_P10:  begin mreq.a = OpW'(k1_q); mreq.b = OpW'(p00_q); mreq.sh32 = 1'b1; end
			STP_P11:  begin mreq.a = OpW'(k1_q); mreq.b = OpW'(p01_q); mreq.sh32 = 1'b1; end
			STP_P00:  begin mreq.a = OpW'(k0_q); mreq.b = OpW'(p00_q); mreq.sh32 = 1'b1; end
			STP_P01:  begin mreq.a = OpW'(k0_q); mreq.b = OpW'(p01_q); mreq.sh32 = 1'b1; end
			default:  begin mreq.a = '0; mreq.b = '0; end
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= ANGLE_NOISE_RST;
			qb_q <= BIAS_NOISE_RST;
			rm_q <= MEASURE_NOISE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ANGLE_NOISE:   qa_q <= cfg_data;
				CFG_BIAS_NOISE:    qb_q <= cfg_data;
				CFG_MEASURE_NOISE: rm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STP_RATE;
			out_valid_q <= 1'b0;
			angle_q     <= '0;
			bias_q      <= '0;
			p00_q       <= '0;
			p01_q       <= '0;
			p10_q       <= '0;
			p11_q       <= '0;
		end else begin
			// load a finished result, or drop the one just taken
			if (state_q == ST_DONE && (!out_valid_q || estimate.ready))
				out_valid_q <= 1'b1;
			else if (estimate.valid && estimate.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						step_q <= STP_RATE;
						if (sample.set_angle) begin
							angle_q <= sample.measured_angle;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (mdone || ddone) begin
						state_q <= last_step ? ST_DONE : ST_ISSUE;
						step_q  <= last_step ? STP_RATE : step_t'(step_q + 4'd1);
						case (step_q)
							STP_RATE: angle_q <= sat32(SumW'(angle_q) + mx);
							STP_DP11: begin
								p01_q <= sat48(SumW'(p01_q) - mx);
								p10_q <= sat48(SumW'(p10_q) - mx);
							end
							STP_T:   p00_q <= sat48(SumW'(p00_q) + mx);
							STP_QB:  p11_q <= sat48(SumW'(p11_q) + mx);
							STP_A:   angle_q <= sat32(SumW'(angle_q) + mx);
							STP_B:   bias_q <= sat32(SumW'(bias_q) + mx);
							STP_P10: p10_q <= sat48(SumW'(p10_q) - mx);
							STP_P11: p11_q <= sat48(SumW'(p11_q) - mx);
							STP_P00: p00_q <= sat48(SumW'(p00_q) - mx);
							STP_P01: p01_q <= sat48(SumW'(p01_q) - mx);
							default: ;
						endcase
					end
				end
				ST_DONE: begin
					// hold the result until the output register frees
					if (!out_valid_q || estimate.ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && sample.valid) begin
			meas_q <= sample.measured_angle;
			rate_q <= sample.measured_rate;
			dt_q   <= sample.time_step;
		end
		if (state_q == ST_DONE && (!out_valid_q || estimate.ready))
			out_q <= angle_q;
		if (state_q == ST_WAIT && mdone && step_q == STP_DP11)
			t_q <= sat48(mx - SumW'(p01_q) - SumW'(p10_q) + SumW'(qa_q));
		if (state_q == ST_ISSUE && step_q == STP_K0)
			y_q <= (AngW+1)'(meas_q) - (AngW+1)'(angle_q);
		if (ddone && step_q == STP_K0)
			k0_q <= dquo;
		if (ddone && step_q == STP_K1)
			k1_q <= dquo;
	end

	assign sample.ready            = (state_q == ST_IDLE);
	assign estimate.valid          = out_valid_q;
	assign estimate.filtered_angle = out_q;

`ifndef ASSERT_OFF
	a_mul_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		mdone |-> (state_q == ST_WAIT && !is_div))
		else $error("multiplier finished outside its step");
	a_div_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		ddone |-> (state_q == ST_WAIT && is_div))
		else $error("divider finished outside a gain step");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && !estimate.ready) |=> state_q == ST_DONE)
		else $error("result overwrote an untaken item");
`endif
endmodule
